@@ rtl/srma_pkg.sv @@
// ----------------------------------------------------------------------------
// srma_pkg: shared types and constants
// Widths, config layout, lane control and the reciprocal table used by the
// spike-reject moving-average filter.
// ----------------------------------------------------------------------------
package srma_pkg;

   localparam int MAX_WINDOW   = 16;
   localparam int SAMPLE_BITS  = 24;
   localparam int FRAC_BITS    = 8;
   localparam int WL_W         = $clog2(MAX_WINDOW);
   localparam int LIMIT_W      = 23;
   localparam int WEIGHT_W     = 9;
   localparam int MEAN_W       = 16;
   localparam int DIFF_W       = SAMPLE_BITS + 1;
   localparam int PROD_W       = DIFF_W + WEIGHT_W + 1;
   localparam int SUM_W        = SAMPLE_BITS + WL_W;
   localparam int MAG_W        = SUM_W - FRAC_BITS;
   localparam int RECIP_K      = MAG_W + WL_W;
   localparam int QUEUE_DEPTH  = 2;
   localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
   localparam int CSR_ADDR_W   = 4;
   localparam int CSR_DATA_W   = 32;
   localparam int REQ_DATA_W   = ((2 * SAMPLE_BITS + 7) / 8) * 8;
   localparam int RSP_DATA_W   = 2 * MEAN_W;

   localparam int WEIGHT_ONE   = 256;
   localparam int ROUND_HALF   = 128;

   localparam logic [WL_W-1:0]     WL_RESET     = WL_W'(5);
   localparam logic [LIMIT_W-1:0]  JUMP_RESET   = LIMIT_W'(1280);
   localparam logic [LIMIT_W-1:0]  MAG_RESET    = LIMIT_W'(2560);
   localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = WEIGHT_W'(230);

   typedef logic signed [SAMPLE_BITS-1:0] sample_type;

   typedef struct packed {
      logic [WL_W-1:0]     window_length;
      logic [LIMIT_W-1:0]  jump_limit;
      logic [LIMIT_W-1:0]  magnitude_limit;
      logic [WEIGHT_W-1:0] blend_weight;
   } cfg_type;

   typedef struct packed {
      logic capture;
      logic blend;
      logic shift;
      logic accumulate;
      logic scale;
      logic divide;
   } lane_ctl_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_BLEND,
      ST_SHIFT,
      ST_SUM,
      ST_SCALE,
      ST_DIVIDE,
      ST_DONE
   } back_state_type;

   typedef enum logic [1:0] {
      CSR_WINDOW_LENGTH   = 2'd0,
      CSR_JUMP_LIMIT      = 2'd1,
      CSR_MAGNITUDE_LIMIT = 2'd2,
      CSR_BLEND_WEIGHT    = 2'd3
   } csr_index_type;

   typedef logic [RECIP_K-1:0] recip_type;
   typedef recip_type recip_table_type [MAX_WINDOW];

   // ceil(2^K / n) for each window length, by shift-subtract at elaboration.
   // With K = MAG_W + WL_W, floor(m * r / 2^K) == floor(m / n) for all m < 2^MAG_W.
   function automatic recip_table_type make_recip_table();
      recip_table_type t;
      logic [RECIP_K:0] num;
      logic [RECIP_K:0] quo;
      logic [WL_W:0]    rem;
      for (int i = 0; i < MAX_WINDOW; i++) begin
         t[i] = '0;
         if (i >= 2) begin
            num = ((RECIP_K + 1)'(1) << RECIP_K) + (RECIP_K + 1)'(i - 1);
            quo = '0;
            rem = '0;
            for (int b = RECIP_K; b >= 0; b--) begin
               rem = {rem[WL_W-1:0], num[b]};
               if (rem >= (WL_W + 1)'(i)) begin
                  rem    = rem - (WL_W + 1)'(i);
                  quo[b] = 1'b1;
               end
            end
            t[i] = quo[RECIP_K-1:0];
         end
      end
      return t;
   endfunction

   localparam recip_table_type RECIP_TABLE = make_recip_table();

endpackage

@@ rtl/srma_csr.sv @@
// ----------------------------------------------------------------------------
// srma_csr: configuration registers
// APB-style write/read port holding window length, limits and blend weight.
// ----------------------------------------------------------------------------
module srma_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [srma_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [srma_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic [srma_pkg::CSR_DATA_W-1:0]   prdata,
   output logic                              pready,
   output srma_pkg::cfg_type                 cfg
);
   import srma_pkg::*;

   cfg_type       cfg_ff;
   cfg_type       cfg_in;
   csr_index_type index;
   logic          write_en;
   logic [WEIGHT_W-1:0] weight_wr;

   assign pready    = 1'b1;
   assign index     = csr_index_type'(paddr[3:2]);
   assign write_en  = psel && penable && pwrite && pready;
   assign weight_wr = pwdata[WEIGHT_W-1:0];
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (write_en) begin
         case (index)
            CSR_WINDOW_LENGTH: begin
               // out-of-range lengths are dropped
               if (pwdata >= CSR_DATA_W'(2) && pwdata < CSR_DATA_W'(MAX_WINDOW)) begin
                  cfg_in.window_length = pwdata[WL_W-1:0];
               end
            end
            CSR_JUMP_LIMIT: begin
               cfg_in.jump_limit = pwdata[LIMIT_W-1:0];
            end
            CSR_MAGNITUDE_LIMIT: begin
               cfg_in.magnitude_limit = pwdata[LIMIT_W-1:0];
            end
            CSR_BLEND_WEIGHT: begin
               cfg_in.blend_weight = (weight_wr > WEIGHT_W'(WEIGHT_ONE)) ?
                                     WEIGHT_W'(WEIGHT_ONE) : weight_wr;
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_comb begin
      case (index)
         CSR_WINDOW_LENGTH:   prdata = CSR_DATA_W'(cfg_ff.window_length);
         CSR_JUMP_LIMIT:      prdata = CSR_DATA_W'(cfg_ff.jump_limit);
         CSR_MAGNITUDE_LIMIT: prdata = CSR_DATA_W'(cfg_ff.magnitude_limit);
         CSR_BLEND_WEIGHT:    prdata = CSR_DATA_W'(cfg_ff.blend_weight);
         default:             prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.window_length   <= WL_RESET;
         cfg_ff.jump_limit      <= JUMP_RESET;
         cfg_ff.magnitude_limit <= MAG_RESET;
         cfg_ff.blend_weight    <= WEIGHT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

@@ rtl/srma_front.sv @@
// ----------------------------------------------------------------------------
// srma_front: request intake
// Accepts point requests into a short queue; the back end pops them.
// ----------------------------------------------------------------------------
module srma_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  srma_pkg::sample_type in_x,
   input  srma_pkg::sample_type in_y,
   input  logic                 pop,
   output logic                 head_valid,
   output srma_pkg::sample_type head_x,
   output srma_pkg::sample_type head_y
);
   import srma_pkg::*;

   sample_type          qx_ff [QUEUE_DEPTH];
   sample_type          qy_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]     count_ff, count_in;
   logic                push;
   logic                do_pop;

   assign in_ready   = (count_ff != (QPTR_W + 1)'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign push       = in_valid && in_ready;
   assign do_pop     = pop && head_valid;
   assign head_x     = qx_ff[rd_ptr_ff];
   assign head_y     = qy_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push   ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff + (QPTR_W + 1)'(push) - (QPTR_W + 1)'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         qx_ff[wr_ptr_ff] <= in_x;
         qy_ff[wr_ptr_ff] <= in_y;
      end
   end

endmodule

@@ rtl/srma_lane.sv @@
// ----------------------------------------------------------------------------
// srma_lane: one axis datapath
// Delay line with spike replacement, window accumulation and scaled mean.
// ----------------------------------------------------------------------------
module srma_lane (
   input  logic                          clock,
   input  logic                          reset,
   input  srma_pkg::lane_ctl_type        ctl,
   input  srma_pkg::cfg_type             cfg,
   input  srma_pkg::sample_type          sample,
   input  logic [srma_pkg::WL_W-1:0]     sum_index,
   output logic signed [srma_pkg::MEAN_W-1:0] mean
);
   import srma_pkg::*;

   localparam int WIDE_W = MAG_W + MEAN_W;
   localparam logic [WIDE_W-1:0] POS_MAX = WIDE_W'(2 ** (MEAN_W - 1) - 1);
   localparam logic [WIDE_W-1:0] NEG_MAX = WIDE_W'(2 ** (MEAN_W - 1));

   sample_type                  line_ff [MAX_WINDOW];
   sample_type                  s_ff;
   logic signed [DIFF_W-1:0]    d_ff;
   logic                        spike_ff;
   logic signed [PROD_W-1:0]    prod_ff;
   logic signed [SUM_W-1:0]     acc_ff;
   logic                        neg_ff;
   logic [MAG_W-1:0]            mag_ff;
   logic [MAG_W-1:0]            quo_ff;

   logic signed [DIFF_W-1:0]    step;
   logic signed [DIFF_W-1:0]    samp_w;
   logic [DIFF_W-1:0]           step_abs;
   logic [DIFF_W-1:0]           samp_abs;
   logic                        spike_in;
   logic signed [DIFF_W-1:0]    older_diff;
   logic signed [WEIGHT_W:0]    weight_s;
   logic signed [PROD_W-1:0]    rounded;
   logic signed [PROD_W-1:0]    adj;
   sample_type                  blended;
   sample_type                  new_sample;
   logic signed [SUM_W-1:0]     acc_term;
   logic [SUM_W-1:0]            acc_abs;
   logic [MAG_W+RECIP_K-1:0]    scaled;
   logic [WIDE_W-1:0]           quo_wide;
   logic [WIDE_W-1:0]           quo_neg;

   always_comb begin
      // spike test against the previous sample, blend toward the one before it
      samp_w     = DIFF_W'(sample);
      step       = samp_w - DIFF_W'(line_ff[0]);
      step_abs   = step[DIFF_W-1]   ? DIFF_W'(-step)   : DIFF_W'(step);
      samp_abs   = samp_w[DIFF_W-1] ? DIFF_W'(-samp_w) : DIFF_W'(samp_w);
      spike_in   = (step_abs > DIFF_W'(cfg.jump_limit)) &&
                   (samp_abs > DIFF_W'(cfg.magnitude_limit));
      older_diff = DIFF_W'(line_ff[1]) - samp_w;
      weight_s   = signed'({1'b0, cfg.blend_weight});

      rounded    = prod_ff + PROD_W'(ROUND_HALF);
      adj        = rounded >>> FRAC_BITS;
      blended    = sample_type'(s_ff + signed'(adj[SAMPLE_BITS-1:0]));
      new_sample = spike_ff ? blended : s_ff;

      acc_term   = SUM_W'(line_ff[sum_index]);
      acc_abs    = acc_ff[SUM_W-1] ? SUM_W'(-acc_ff) : SUM_W'(acc_ff);

      scaled     = (MAG_W + RECIP_K)'(mag_ff) *
                   (MAG_W + RECIP_K)'(RECIP_TABLE[cfg.window_length]);

      // saturate to the mean width
      quo_wide   = WIDE_W'(quo_ff);
      quo_neg    = WIDE_W'(0) - quo_wide;
      if (neg_ff) begin
         mean = (quo_wide > NEG_MAX) ? signed'(MEAN_W'(NEG_MAX)) :
                                       signed'(quo_neg[MEAN_W-1:0]);
      end else begin
         mean = (quo_wide > POS_MAX) ? signed'(MEAN_W'(POS_MAX)) :
                                       signed'(quo_wide[MEAN_W-1:0]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_WINDOW; i++) begin
            line_ff[i] <= '0;
         end
      end else if (ctl.shift) begin
         for (int i = MAX_WINDOW - 1; i > 0; i--) begin
            line_ff[i] <= line_ff[i-1];
         end
         line_ff[0] <= new_sample;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.capture) begin
         s_ff     <= sample;
         d_ff     <= older_diff;
         spike_ff <= spike_in;
      end
      if (ctl.blend) begin
         prod_ff <= PROD_W'(weight_s) * PROD_W'(d_ff);
      end
      if (ctl.shift) begin
         acc_ff <= '0;
      end else if (ctl.accumulate) begin
         acc_ff <= acc_ff + acc_term;
      end
      if (ctl.scale) begin
         neg_ff <= acc_ff[SUM_W-1];
         mag_ff <= acc_abs[SUM_W-1:FRAC_BITS];
      end
      if (ctl.divide) begin
         quo_ff <= scaled[MAG_W+RECIP_K-1:RECIP_K];
      end
   end

endmodule

@@ rtl/srma_back.sv @@
// ----------------------------------------------------------------------------
// srma_back: filter sequencer
// Pops queued requests, steps both axis lanes and holds the result register.
// ----------------------------------------------------------------------------
module srma_back (
   input  logic                              clock,
   input  logic                              reset,
   input  srma_pkg::cfg_type                 cfg,
   input  logic                              head_valid,
   input  srma_pkg::sample_type              head_x,
   input  srma_pkg::sample_type              head_y,
   output logic                              pop,
   output logic                              out_valid,
   input  logic                              out_ready,
   output logic signed [srma_pkg::MEAN_W-1:0] out_mean_x,
   output logic signed [srma_pkg::MEAN_W-1:0] out_mean_y
);
   import srma_pkg::*;

   back_state_type        state_ff, state_in;
   logic [WL_W-1:0]       idx_ff, idx_in;
   lane_ctl_type          ctl;
   logic                  load_out;
   logic                  out_valid_ff;
   logic signed [MEAN_W-1:0] mean_x_ff, mean_y_ff;
   logic signed [MEAN_W-1:0] lane_mean_x, lane_mean_y;

   srma_lane u_lane_x (
      .clock     (clock),
      .reset     (reset),
      .ctl       (ctl),
      .cfg       (cfg),
      .sample    (head_x),
      .sum_index (idx_ff),
      .mean      (lane_mean_x)
   );

   srma_lane u_lane_y (
      .clock     (clock),
      .reset     (reset),
      .ctl       (ctl),
      .cfg       (cfg),
      .sample    (head_y),
      .sum_index (idx_ff),
      .mean      (lane_mean_y)
   );

   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      ctl      = '0;
      pop      = 1'b0;
      load_out = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (head_valid) begin
               pop         = 1'b1;
               ctl.capture = 1'b1;
               state_in    = ST_BLEND;
            end
         end
         ST_BLEND: begin
            ctl.blend = 1'b1;
            state_in  = ST_SHIFT;
         end
         ST_SHIFT: begin
            ctl.shift = 1'b1;
            idx_in    = '0;
            state_in  = ST_SUM;
         end
         ST_SUM: begin
            ctl.accumulate = 1'b1;
            idx_in         = idx_ff + WL_W'(1);
            if (idx_ff == cfg.window_length - WL_W'(1)) begin
               state_in = ST_SCALE;
            end
         end
         ST_SCALE: begin
            ctl.scale = 1'b1;
            state_in  = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            ctl.divide = 1'b1;
            state_in   = ST_DONE;
         end
         ST_DONE: begin
            if (!out_valid_ff || out_ready) begin
               load_out = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         idx_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
         if (load_out) begin
            out_valid_ff <= 1'b1;
         end else if (out_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load_out) begin
         mean_x_ff <= lane_mean_x;
         mean_y_ff <= lane_mean_y;
      end
   end

   assign out_valid  = out_valid_ff;
   assign out_mean_x = mean_x_ff;
   assign out_mean_y = mean_y_ff;

endmodule

@@ rtl/spike_reject_moving_average_2d_top.sv @@
// ----------------------------------------------------------------------------
// spike_reject_moving_average_2d_top: 2-D moving average with spike rejection
// Per-axis delay lines, spike replacement by blend, truncated window mean.
// ----------------------------------------------------------------------------
// Usage:
//   req_* is a stream slave carrying one point (x, y) per request, signed
//   Q.8. rsp_* is a stream master returning one pair of integer window
//   means per request, in request order. csr_* is an APB-style port for
//   window length, jump limit, magnitude limit and blend weight; write it
//   only while no request is in flight.
// Timing:
//   The back end steps through capture, blend multiply, line shift, one
//   window tap per cycle into the sum, scale, reciprocal multiply and
//   result load. It takes no new request from the queue until its result
//   is loaded, so this whole sequence sets the throughput.
// Stalls:
//   A two-entry request queue decouples intake from the back end, so
//   req_tready stays high until the queue holds two requests. If rsp_tready
//   is low the sequencer holds its finished result until the output
//   register frees; the queue then fills and req_tready drops.
// Reset:
//   Synchronous; clears both delay lines to zero, empties the queue, drops
//   rsp_tvalid and restores the register defaults (5, 5.0, 10.0, 0.9).
// ----------------------------------------------------------------------------
module spike_reject_moving_average_2d_top (
   input  logic                              clock,
   input  logic                              reset,
   // request channel
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [srma_pkg::REQ_DATA_W-1:0]   req_tdata,   // sample_x, sample_y
   // result channel
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [srma_pkg::RSP_DATA_W-1:0]   rsp_tdata,   // mean_x, mean_y
   // configuration port
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [srma_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [srma_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [srma_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                              csr_pready
);
   import srma_pkg::*;

   cfg_type     cfg;
   sample_type  req_x, req_y;
   sample_type  head_x, head_y;
   logic        head_valid;
   logic        pop;
   logic signed [MEAN_W-1:0] mean_x, mean_y;

   // unpack request fields, x in the low bits
   assign req_x = signed'(req_tdata[SAMPLE_BITS-1:0]);
   assign req_y = signed'(req_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]);

   srma_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready),
      .cfg     (cfg)
   );

   // front: request queue
   srma_front u_front (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .in_x       (req_x),
      .in_y       (req_y),
      .pop        (pop),
      .head_valid (head_valid),
      .head_x     (head_x),
      .head_y     (head_y)
   );

   // back: sequencer, axis lanes, output register
   srma_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .head_valid (head_valid),
      .head_x     (head_x),
      .head_y     (head_y),
      .pop        (pop),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_mean_x (mean_x),
      .out_mean_y (mean_y)
   );

   // pack results, x in the low half
   assign rsp_tdata = {mean_y, mean_x};

endmodule
